@@ hdl/pmc_pkg.sv @@
// Package for the per-column missing counter.
// Holds payload structs, the cell control struct and fixed widths; no dependencies.
`default_nettype none

package pmc_pkg;

  localparam int unsigned LenW        = 16;  // row length and counter width
  localparam int unsigned CfgW        = 5;   // max_columns register width
  localparam int unsigned PosW        = 4;   // column position field width
  localparam int unsigned ResultLimit = 16;  // most results one row can emit
  localparam int unsigned RemainW     = 5;   // holds 0 .. ResultLimit

  typedef struct packed {
    logic [LenW-1:0] row_length;
    logic            first_in_bin;
  } in_t;

  typedef struct packed {
    logic [LenW-1:0] missing_count;
    logic [PosW-1:0] position;
    logic            too_long;
    logic            last;
  } out_t;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic            update;     // count the accepted row
    logic            clear;      // bin start: zero before counting
    logic            load;       // copy updated counters into the read chain
    logic            shift;      // move the read chain one cell toward cell 0
    logic [LenW-1:0] row_length;
    logic [LenW-1:0] cols;       // column positions in use
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/pmc_cell.sv @@
// One column position: saturating counter plus one stage of the read chain.
// Depends on pmc_pkg.
`default_nettype none

module pmc_cell import pmc_pkg::*; #(
  parameter int unsigned Index = 0
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire cell_ctrl_t  ctrl_i,
  input  wire  [LenW-1:0]  tap_i,   // from the neighbor one position up
  output logic [LenW-1:0]  tap_o
);

  localparam logic [LenW-1:0] IdxL = LenW'(Index);

  logic [LenW-1:0] counter_q, counter_d;
  logic [LenW-1:0] tap_q, tap_d;
  logic [LenW-1:0] base;
  logic            in_range;

  always_comb begin
    base      = ctrl_i.clear ? '0 : counter_q;
    in_range  = (IdxL >= ctrl_i.row_length) && (IdxL < ctrl_i.cols);
    counter_d = counter_q;
    if (ctrl_i.update) begin
      counter_d = base;
      if (in_range && (base != '1)) begin
        counter_d = base + LenW'(1);
      end
    end
  end

  always_comb begin
    tap_d = tap_q;
    if (ctrl_i.load) begin
      tap_d = counter_d;
    end else if (ctrl_i.shift) begin
      tap_d = tap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
    end else begin
      counter_q <= counter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_q <= tap_d;
  end

  assign tap_o = tap_q;

endmodule

`default_nettype wire

@@ hdl/per_column_missing_counter.sv @@
// Top level of the per-column missing counter: sequencer and a chain of pmc_cell.
// Depends on pmc_pkg and pmc_cell.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_t  (row_length, first_in_bin)
//  out     | output    | out_valid/out_ready| out_t (missing_count, position, too_long, last)
//  cfg     | input     | cfg_we             | max_columns, 5 bits, no wait
//
// A row is counted in the cycle it is accepted; all cells update in parallel and
// copy their counts into the read chain, which then moves one cell per result.
// A row of n results is emitted at one result per cycle when out_ready is high;
// an empty or zero-column row emits no results. The next row is accepted in the
// cycle the last result is taken. A stall on out holds the chain and the result.
// Reset zeroes all counters and sets max_columns to 16.
`default_nettype none

module per_column_missing_counter import pmc_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 16
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  wire in_t        in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output out_t            out_data_o,
  input  wire             cfg_we_i,
  input  wire  [CfgW-1:0] cfg_data_i
);

  localparam logic [LenW-1:0] MaxColsL = LenW'(MAX_COLUMNS);
  localparam logic [LenW-1:0] LimitL   = LenW'(ResultLimit);

  logic [CfgW-1:0]    max_columns_q;
  logic               out_valid_q, out_valid_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [RemainW-1:0] remain_q, remain_d;
  logic               clip_q, clip_d;

  logic               in_acc, out_acc, is_last;
  logic [LenW-1:0]    cols, emit_a, emit;
  cell_ctrl_t         ctrl;
  logic [LenW-1:0]    taps [MAX_COLUMNS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_columns_q <= CfgW'(16);
    end else if (cfg_we_i) begin
      max_columns_q <= cfg_data_i;
    end
  end

  always_comb begin
    cols   = (LenW'(max_columns_q) > MaxColsL) ? MaxColsL : LenW'(max_columns_q);
    emit_a = (in_data_i.row_length < cols) ? in_data_i.row_length : cols;
    emit   = (emit_a > LimitL) ? LimitL : emit_a;
  end

  assign is_last    = (remain_q == RemainW'(1));
  assign out_acc    = out_valid_q && out_ready_i;
  assign in_ready_o = !out_valid_q || (out_ready_i && is_last);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    ctrl.update     = in_acc;
    ctrl.clear      = in_acc && in_data_i.first_in_bin;
    ctrl.load       = in_acc;
    ctrl.shift      = out_acc;
    ctrl.row_length = in_data_i.row_length;
    ctrl.cols       = cols;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    remain_d    = remain_q;
    clip_d      = clip_q;
    if (in_acc) begin
      // new row overrides the final transaction of the old one
      out_valid_d = (emit != '0);
      pos_d       = '0;
      remain_d    = RemainW'(emit);
      clip_d      = (in_data_i.row_length > emit);
    end else if (out_acc) begin
      out_valid_d = !is_last;
      pos_d       = pos_q + PosW'(1);
      remain_d    = remain_q - RemainW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      remain_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      remain_q    <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clip_q <= clip_d;
  end

  assign taps[MAX_COLUMNS] = '0;

  for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_cell
    pmc_cell #(
      .Index (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .tap_i  (taps[k+1]),
      .tap_o  (taps[k])
    );
  end

  always_comb begin
    out_data_o.missing_count = taps[0];
    out_data_o.position      = pos_q;
    out_data_o.too_long      = clip_q;
    out_data_o.last          = is_last;
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_valid_has_remaining : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (remain_q != '0))
    else $error("result shown with nothing left to emit");

  a_within_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((RemainW'(pos_q) + remain_q) <= RemainW'(ResultLimit)))
    else $error("position plus remaining exceeds result limit");

  a_ready_only_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || (out_ready_i && out_data_o.last)))
    else $error("row accepted while results are still pending");

  a_row_starts_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (pos_q == '0))
    else $error("new row does not start at position zero");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for per_column_missing_counter: a directed table and random phases
// over several column settings. The table or a local predictor checks each result.
// Depends on pmc_pkg and the RTL under hdl/.
`default_nettype none

module tb;
  import pmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCols   = 16;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned MaxShown  = 10;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgW-1:0]     cfg_val;
    in_t                 row;
    logic                typed;    // expected results written out below
    logic [RemainW-1:0]  n;
    logic [LenW-1:0]     cnt;      // every typed result carries this count
    logic                clip;
  } step_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;

  // Predictor state
  logic [LenW-1:0] col_count [MaxCols];
  logic [CfgW-1:0] cols_reg;
  out_t            row_out [ResultLimit];
  out_t            counts_due [$];

  bit          idling = 1'b1;
  bit          hold_out = 1'b0;
  int unsigned errors = 0;
  int unsigned rows_sent = 0;
  int unsigned counts_checked = 0;
  int unsigned settings = 0;
  int unsigned quiet_cycles = 0;

  per_column_missing_counter #(.MAX_COLUMNS(MaxCols)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Update the counters for one row and fill row_out; returns the number of results.
  function automatic int unsigned count_row(input in_t r);
    int unsigned len;
    int unsigned cols;
    int unsigned emit;
    len  = r.row_length;
    cols = (cols_reg > MaxCols) ? MaxCols : cols_reg;
    if (r.first_in_bin) begin
      for (int k = 0; k < MaxCols; k++) col_count[k] = '0;
    end
    for (int k = len; k < cols; k++) begin
      if (col_count[k] != '1) col_count[k] = col_count[k] + 1'b1;
    end
    emit = (len < cols) ? len : cols;
    if (emit > ResultLimit) emit = ResultLimit;
    for (int k = 0; k < emit; k++) begin
      row_out[k].missing_count = col_count[k];
      row_out[k].position      = PosW'(k);
      row_out[k].too_long      = (len > emit);
      row_out[k].last          = (k + 1 == emit);
    end
    return emit;
  endfunction

  function automatic step_t row_step(input logic [LenW-1:0] len, input logic bin);
    step_t s;
    s = '0;
    s.row.row_length   = len;
    s.row.first_in_bin = bin;
    return s;
  endfunction

  function automatic step_t known_step(input logic [LenW-1:0] len, input logic bin,
                                       input logic [RemainW-1:0] n,
                                       input logic [LenW-1:0] cnt, input logic clip);
    step_t s;
    s = row_step(len, bin);
    s.typed = 1'b1;
    s.n     = n;
    s.cnt   = cnt;
    s.clip  = clip;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [CfgW-1:0] v);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.cfg_val = v;
    return s;
  endfunction

  function automatic void flag_error(input string what, input out_t want, input out_t got);
    errors++;
    if (errors <= MaxShown) begin
      $display("ERROR %s: expected count %0d pos %0d too_long %b last %b",
               what, want.missing_count, want.position, want.too_long, want.last);
      $display("  got count %0d pos %0d too_long %b last %b",
               got.missing_count, got.position, got.too_long, got.last);
    end
  endfunction

  task automatic send_row(input in_t r, input bit typed, input int unsigned n,
                          input logic [LenW-1:0] cnt, input bit clip);
    int unsigned gap;
    int unsigned emit;
    out_t t;
    gap = idling ? $urandom_range(16, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    // transaction taken at this edge
    emit = count_row(r);
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        t.missing_count = cnt;
        t.position      = PosW'(k);
        t.too_long      = clip;
        t.last          = (k + 1 == n);
        counts_due.push_back(t);
      end
    end else begin
      for (int k = 0; k < emit; k++) counts_due.push_back(row_out[k]);
    end
    rows_sent++;
  endtask

  // Stop input, drain the pending results, then write the register.
  task automatic write_cols(input logic [CfgW-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (counts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cols_reg = v;
    settings++;
  endtask

  // Receiver: random stalls per result while idling is set, one long hold-off on request.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        stall    = 300;
        hold_out = 1'b0;
      end else begin
        stall = idling ? $urandom_range(16, 0) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  // Sample at the falling edge, where everything has settled.
  always @(negedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && out_ready_i) begin
        counts_checked++;
        if (counts_due.size() == 0) begin
          flag_error("unexpected result", '0, out_data_o);
        end else begin
          want = counts_due.pop_front();
          if (out_data_o.missing_count !== want.missing_count ||
              out_data_o.position !== want.position ||
              out_data_o.too_long !== want.too_long ||
              out_data_o.last !== want.last)
            flag_error("result mismatch", want, out_data_o);
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, counts_due.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    step_t       plan [$];
    step_t       s;
    in_t         r;
    int unsigned eff;
    int unsigned sel;
    int unsigned n_items;
    logic [CfgW-1:0] phase_cols [7];

    for (int k = 0; k < MaxCols; k++) col_count[k] = '0;
    cols_reg = 5'd16;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = '{
      known_step(16'd0,     1'b1, 5'd0,  16'd0, 1'b0),
      known_step(16'd16,    1'b1, 5'd16, 16'd0, 1'b0),
      known_step(16'hFFFF,  1'b0, 5'd16, 16'd0, 1'b1),
      known_step(16'd17,    1'b0, 5'd16, 16'd0, 1'b1),
      known_step(16'd1,     1'b0, 5'd1,  16'd0, 1'b0),
      row_step(16'd15, 1'b0),
      row_step(16'd0,  1'b0),
      row_step(16'd3,  1'b0),
      known_step(16'd8,     1'b1, 5'd8,  16'd0, 1'b0),
      row_step(16'h8000, 1'b0),
      row_step(16'h5555, 1'b0),
      known_step(16'hAAAA,  1'b1, 5'd16, 16'd0, 1'b1),
      row_step(16'd2,  1'b0),
      row_step(16'd5,  1'b0),
      row_step(16'd16, 1'b0),
      // no columns in use: nothing is counted or emitted
      cfg_step(5'd0),
      known_step(16'd5,     1'b1, 5'd0,  16'd0, 1'b0),
      known_step(16'd0,     1'b0, 5'd0,  16'd0, 1'b0),
      known_step(16'hFFFF,  1'b0, 5'd0,  16'd0, 1'b0),
      cfg_step(5'd1),
      row_step(16'd0, 1'b1),
      row_step(16'd1, 1'b0),
      row_step(16'd2, 1'b0),
      // oversized setting saturates; counters past the old width keep their values
      cfg_step(5'd31),
      row_step(16'd16, 1'b0),
      row_step(16'd20, 1'b0),
      row_step(16'd4,  1'b0)
    };
    foreach (plan[i]) begin
      s = plan[i];
      if (s.is_cfg) write_cols(s.cfg_val);
      else send_row(s.row, s.typed, s.n, s.cnt, s.clip);
    end

    phase_cols = '{5'($urandom_range(15, 2)), 5'd31, 5'd1, 5'd0,
                   5'($urandom_range(30, 17)), 5'd16, 5'($urandom_range(31, 0))};
    foreach (phase_cols[p]) begin
      write_cols(phase_cols[p]);
      idling  = (p % 3 != 2);
      n_items = (phase_cols[p] == 0) ? 20 : 52;
      eff     = (cols_reg > MaxCols) ? MaxCols : cols_reg;
      for (int i = 0; i < n_items; i++) begin
        if (p == 1 && i == 20) hold_out = 1'b1;
        if (p == 2 && i == 30) begin
          // hold input until every pending count has drained
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (counts_due.size() != 0) @(posedge clk_i);
        end
        sel = $urandom_range(9, 0);
        r.first_in_bin = ($urandom_range(7, 0) == 0);
        if (sel < 7)      r.row_length = LenW'($urandom_range(eff + 2, 0));
        else if (sel < 9) r.row_length = LenW'($urandom_range(16, 0));
        else              r.row_length = LenW'($urandom());
        send_row(r, 1'b0, 0, '0, 1'b0);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (counts_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d rows and %0d column counts over directed edge cases and random rows,",
             rows_sent, counts_checked);
    $display("across %0d register writes from zero through oversized column settings.",
             settings);
    if (errors == 0 && counts_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors, %0d results never seen", errors, counts_due.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
